/* hw/rtl/delayed_task_timer_table_macros.svh */
// Assertion macros used by the timer table checker.
`ifndef DELAYED_TASK_TIMER_TABLE_MACROS_SVH
`define DELAYED_TASK_TIMER_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dtt_pkg.sv */
// Shared types, codes and constants of the timer slot table.
package dtt_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int RESULT_LIMIT  = 16;
    localparam int CNT_W         = $clog2(RESULT_LIMIT + 1);
    localparam int TIME_W        = 32;
    localparam int REP_W         = 17;
    localparam int OP_W          = 2;
    localparam int KIND_W        = 2;
    localparam int SLOT_OUT_W    = 4;

    typedef enum logic [OP_W-1:0] {
        OP_SCHED = 2'd0,
        OP_FREE  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd2;

    // One slot of the table as held in the slot memory.
    typedef struct packed {
        logic                     waiting;
        logic        [TIME_W-1:0] last_time;
        logic signed [TIME_W-1:0] delay;
        logic signed [TIME_W-1:0] period;
        logic signed [TIME_W-1:0] run_left;
        logic signed [REP_W-1:0]  repeats;
    } dtt_entry_t;

    // Outcome of evaluating one slot during a tick.
    typedef struct packed {
        logic       fire;
        logic       spent;
        dtt_entry_t entry;
    } dtt_eval_t;

endpackage

/* hw/rtl/dtt_slot_mem.sv */
// Slot memory: one write port, one read port with registered read data.
module dtt_slot_mem
    import dtt_pkg::*;
#(
    parameter int DEPTH  = NUM_SLOTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  dtt_entry_t        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output dtt_entry_t        rd_data
);

    dtt_entry_t mem_reg [DEPTH];
    dtt_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read data holds while no read is issued, so a stalled scan keeps its slot.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/dtt_slot_eval.sv */
// Timer rules for one slot at a tick: wait, run phase, repeat phase, spent.
module dtt_slot_eval
    import dtt_pkg::*;
(
    input  dtt_entry_t        entry,
    input  logic [TIME_W-1:0] now,
    output dtt_eval_t         result
);

    logic signed [TIME_W-1:0] elapsed;
    logic signed [TIME_W:0]   run_diff;
    logic signed [TIME_W-1:0] run_sat;
    logic signed [REP_W-1:0]  rep_dec;
    logic                     period_ok;

    assign elapsed = now - entry.last_time;

    // Saturating run_left - elapsed in one extra bit.
    assign run_diff = {entry.run_left[TIME_W-1], entry.run_left}
                    - {elapsed[TIME_W-1], elapsed};

    always_comb
    begin
        if (run_diff[TIME_W] != run_diff[TIME_W-1])
        begin
            run_sat = run_diff[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}}
                                       : {1'b0, {(TIME_W-1){1'b1}}};
        end
        else
        begin
            run_sat = run_diff[TIME_W-1:0];
        end
    end

    assign rep_dec   = (entry.repeats > 0) ? entry.repeats - 17'sd1 : entry.repeats;
    assign period_ok = (entry.period <= 0) || (entry.period <= elapsed);

    always_comb
    begin
        result.fire  = 1'b0;
        result.spent = 1'b0;
        result.entry = entry;
        if (entry.waiting)
        begin
            if (elapsed > entry.delay)
            begin
                result.fire            = 1'b1;
                result.entry.waiting   = 1'b0;
                result.entry.repeats   = rep_dec;
                result.entry.last_time = now;
            end
        end
        else if (entry.run_left > 0)
        begin
            if (period_ok)
            begin
                result.fire            = 1'b1;
                result.entry.run_left  = run_sat;
                result.entry.repeats   = rep_dec;
                result.entry.last_time = now;
            end
        end
        else if ((entry.repeats > 0) || (entry.repeats == -1))
        begin
            if (period_ok)
            begin
                result.fire            = 1'b1;
                result.entry.repeats   = rep_dec;
                result.entry.last_time = now;
            end
        end
        else
        begin
            result.spent = 1'b1;
        end
    end

endmodule

/* hw/rtl/delayed_task_timer_table.sv */
// Top level of the timer slot table: valid bits, scan sequencer and result register.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+----------------------------------------------------
//  in      | in_valid / in_ready | op, now, start_delay, period, run_length,
//          |                     | repeat_count, slot_to_free
//  out     | out_valid/out_ready | kind, slot, last
//
// A schedule item writes its slot, then the flush state moves its answer to the result register.
// A free item clears the valid bit of its slot. A tick item ends in the flush state when it fires,
// and the scan, when not paused, looks at one slot per cycle through the single read port.
// Reset clears the valid bits but not the slot memory, which needs no clearing pass.
// The scan pauses whenever a fire must be handed on while the result register is still full.
module delayed_task_timer_table
    import dtt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          op,
    input  logic [TIME_W-1:0]        now,
    input  logic signed [TIME_W-1:0] start_delay,
    input  logic signed [TIME_W-1:0] period,
    input  logic signed [TIME_W-1:0] run_length,
    input  logic signed [REP_W-1:0]  repeat_count,
    input  logic [SLOT_OUT_W-1:0]    slot_to_free,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [KIND_W-1:0]        kind,
    output logic [SLOT_OUT_W-1:0]    slot,
    output logic                     last
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                  state_reg, state_next;
    logic [NUM_SLOTS-1:0]    valid_reg, valid_next;
    logic [SLOT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]        fire_cnt_reg, fire_cnt_next;
    logic [TIME_W-1:0]       now_reg, now_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [KIND_W-1:0]       pend_kind_reg, pend_kind_next;
    logic [SLOT_OUT_W-1:0]   pend_slot_reg, pend_slot_next;
    logic                    out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]       out_kind_reg, out_kind_next;
    logic [SLOT_OUT_W-1:0]   out_slot_reg, out_slot_next;
    logic                    out_last_reg, out_last_next;

    logic                    wr_en;
    logic [SLOT_W-1:0]       wr_addr;
    dtt_entry_t              wr_data;
    logic                    rd_en;
    logic [SLOT_W-1:0]       rd_addr;
    dtt_entry_t              rd_data;
    dtt_eval_t               eval;

    logic                    accept;
    logic                    out_free;
    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;
    logic                    slot_live;
    logic                    take;
    logic                    need_emit;
    dtt_entry_t              sched_entry;

    dtt_slot_mem #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dtt_slot_eval u_slot_eval (
        .entry  (rd_data),
        .now    (now_reg),
        .result (eval)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign slot      = out_slot_reg;
    assign last      = out_last_reg;

    // Lowest empty slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        sched_entry.waiting   = 1'b1;
        sched_entry.last_time = now;
        sched_entry.delay     = start_delay;
        sched_entry.period    = period;
        sched_entry.run_left  = run_length;
        sched_entry.repeats   = repeat_count;
    end

    // A fire is held back in the pending register so the final fire of a tick can carry last.
    assign slot_live = valid_reg[scan_idx_reg];
    assign take      = slot_live && eval.fire && (fire_cnt_reg < CNT_W'(RESULT_LIMIT));
    assign need_emit = take && pend_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        scan_idx_next   = scan_idx_reg;
        fire_cnt_next   = fire_cnt_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_slot_next  = pend_slot_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = scan_idx_reg;
        wr_data         = eval.entry;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(op))
                        OP_SCHED:
                        begin
                            pend_valid_next = 1'b1;
                            state_next      = ST_FLUSH;
                            if (free_found)
                            begin
                                wr_en                = 1'b1;
                                wr_addr              = free_idx;
                                wr_data              = sched_entry;
                                valid_next[free_idx] = 1'b1;
                                pend_kind_next       = KIND_ACCEPT;
                                pend_slot_next       = SLOT_OUT_W'(free_idx);
                            end
                            else
                            begin
                                pend_kind_next = KIND_FULL;
                                pend_slot_next = '0;
                            end
                        end
                        OP_FREE:
                        begin
                            if (int'(slot_to_free) < NUM_SLOTS)
                            begin
                                valid_next[SLOT_W'(slot_to_free)] = 1'b0;
                            end
                        end
                        OP_TICK:
                        begin
                            now_next        = now;
                            rd_en           = 1'b1;
                            rd_addr         = '0;
                            scan_idx_next   = '0;
                            fire_cnt_next   = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Write-back of this slot and the read of the next never share an entry.
                if (!need_emit || out_free)
                begin
                    if (slot_live)
                    begin
                        if (eval.spent)
                        begin
                            valid_next[scan_idx_reg] = 1'b0;
                        end
                        wr_en = eval.fire;
                    end
                    if (need_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = pend_kind_reg;
                        out_slot_next  = pend_slot_reg;
                        out_last_next  = 1'b0;
                    end
                    if (take)
                    begin
                        pend_valid_next = 1'b1;
                        pend_kind_next  = KIND_FIRE;
                        pend_slot_next  = SLOT_OUT_W'(scan_idx_reg);
                        fire_cnt_next   = fire_cnt_reg + CNT_W'(1);
                    end
                    if (scan_idx_reg == SLOT_W'(NUM_SLOTS - 1))
                    begin
                        state_next = pend_valid_next ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + SLOT_W'(1);
                        rd_en         = 1'b1;
                        rd_addr       = scan_idx_reg + SLOT_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_slot_next   = pend_slot_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            scan_idx_reg   <= '0;
            fire_cnt_reg   <= '0;
            now_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_kind_reg  <= KIND_ACCEPT;
            pend_slot_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_ACCEPT;
            out_slot_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            scan_idx_reg   <= scan_idx_next;
            fire_cnt_reg   <= fire_cnt_next;
            now_reg        <= now_next;
            pend_valid_reg <= pend_valid_next;
            pend_kind_reg  <= pend_kind_next;
            pend_slot_reg  <= pend_slot_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_slot_reg   <= out_slot_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule

/* hw/rtl/dtt_checker.sv */
// Port-level checks of the timer slot table and their binding to the top level.
`include "delayed_task_timer_table_macros.svh"

module dtt_checker
    import dtt_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [OP_W-1:0]          op,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [KIND_W-1:0]        kind,
    input logic [SLOT_OUT_W-1:0]    slot,
    input logic                     last
);

    // A result that is not taken stays in place.
    `DTT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(kind) && $stable(slot) && $stable(last),
        "result changed while stalled")

    // A schedule item always leaves an answer to deliver, so no item follows at once.
    `DTT_ASSERT_NEXT(a_sched_busy, clk, rst_n, in_valid && in_ready && (op == OP_SCHED),
        !in_ready, "input taken while a schedule answer is pending")

    // A full table answers with slot zero as the only result.
    `DTT_ASSERT_NOW(a_full_form, clk, rst_n, out_valid && (kind == KIND_FULL),
        (slot == '0) && last, "malformed table full result")

    // An accepted schedule is always the single result of its item.
    `DTT_ASSERT_NOW(a_accept_last, clk, rst_n, out_valid && (kind == KIND_ACCEPT),
        last, "schedule answer without last")

endmodule

bind delayed_task_timer_table dtt_checker u_dtt_checker (.*);
